>>> rtl/arm_pkg.sv
`default_nettype none
package arm_pkg;

  localparam int MAX_RANGES = 16;
  localparam int CHAR_W     = 31;
  localparam int IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int LEN_W      = CHAR_W + 1;
  localparam int ACC_W      = CHAR_W + CNT_W + 1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_LREAD,
    S_LEVAL,
    S_CREAD,
    S_CEVAL,
    S_MREAD,
    S_MEVAL,
    S_FLUSH,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [CHAR_W-1:0] s;
    logic [CHAR_W-1:0] e;
  } range_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    logic    rd;
    logic    inc_i;
    logic    clr_i;
    logic    acc_add;
    logic    set_code;
    logic    take_new;
    logic    take_ram;
    logic    flush;
    logic    set_status;
    status_t status;
    logic    out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_lookup;
    logic ch_zero;
    logic empty;
    logic full;
    logic at_end;
    logic lk_hit;
    logic touch;
    logic new_first;
    logic new_taken;
    logic rsp_free;
  } sts_t;

  function automatic logic [LEN_W-1:0] range_len(input range_t r);
    return {1'b0, r.e} - {1'b0, r.s} + LEN_W'(1);
  endfunction

  function automatic logic [CHAR_W-1:0] sat_char(input logic [ACC_W-1:0] v);
    return (|v[ACC_W-1:CHAR_W]) ? {CHAR_W{1'b1}} : v[CHAR_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/arm_if.sv
`default_nettype none
interface arm_req_if;
  import arm_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [CHAR_W-1:0] range_first;
  logic [CHAR_W-1:0] range_last;
  logic [CHAR_W-1:0] character;

  modport source (output valid, op, range_first, range_last, character, input ready);
  modport sink   (input valid, op, range_first, range_last, character, output ready);
endinterface

interface arm_rsp_if;
  import arm_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] code;
  status_t           status;
  logic [CHAR_W-1:0] alphabet_size;

  modport source (output valid, code, status, alphabet_size, input ready);
  modport sink   (input valid, code, status, alphabet_size, output ready);
endinterface
`default_nettype wire

>>> rtl/arm_ram.sv
`default_nettype none
module arm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

>>> rtl/arm_ctrl.sv
`default_nettype none
module arm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  output arm_pkg::cmd_t      cmd,
  input  wire arm_pkg::sts_t sts
);
  import arm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (sts.is_lookup) begin
          if (sts.ch_zero) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_OK;
            state_next     = S_FIN;
          end else begin
            state_next = S_LREAD;
          end
        end else if (sts.empty) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_EMPTY;
          state_next     = S_FIN;
        end else if (sts.full) begin
          state_next = S_CREAD;
        end else begin
          state_next = S_MREAD;
        end
      end
      S_LREAD: begin
        if (sts.at_end) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_MISS;
          state_next     = S_FIN;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_LEVAL;
        end
      end
      S_LEVAL: begin
        if (sts.lk_hit) begin
          cmd.set_code   = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = ST_OK;
          state_next     = S_FIN;
        end else begin
          cmd.acc_add = 1'b1;
          cmd.inc_i   = 1'b1;
          state_next  = S_LREAD;
        end
      end
      S_CREAD: begin
        if (sts.at_end) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_FULL;
          state_next     = S_FIN;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_CEVAL;
        end
      end
      S_CEVAL: begin
        if (sts.touch) begin
          cmd.clr_i  = 1'b1;
          state_next = S_MREAD;
        end else begin
          cmd.inc_i  = 1'b1;
          state_next = S_CREAD;
        end
      end
      S_MREAD: begin
        if (sts.at_end) begin
          if (!sts.new_taken) begin
            cmd.take_new = 1'b1;
          end else begin
            state_next = S_FLUSH;
          end
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_MEVAL;
        end
      end
      S_MEVAL: begin
        if (!sts.new_taken && sts.new_first) begin
          cmd.take_new = 1'b1;
        end else begin
          cmd.take_ram = 1'b1;
          cmd.inc_i    = 1'b1;
          state_next   = S_MREAD;
        end
      end
      S_FLUSH: begin
        cmd.flush      = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status     = ST_OK;
        state_next     = S_FIN;
      end
      S_FIN: begin
        if (sts.rsp_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/arm_dp.sv
`default_nettype none
module arm_dp (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire arm_pkg::cmd_t         cmd,
  output arm_pkg::sts_t              sts,
  input  wire logic                  op,
  input  wire logic [arm_pkg::CHAR_W-1:0] range_first,
  input  wire logic [arm_pkg::CHAR_W-1:0] range_last,
  input  wire logic [arm_pkg::CHAR_W-1:0] character,
  output logic                       rsp_valid,
  input  wire logic                  rsp_ready,
  output logic [arm_pkg::CHAR_W-1:0] rsp_code,
  output arm_pkg::status_t           rsp_status,
  output logic [arm_pkg::CHAR_W-1:0] rsp_size
);
  import arm_pkg::*;

  logic              op_r;
  logic [CHAR_W-1:0] first_r, last_r, ch_r;
  logic [CNT_W-1:0]  i_r, w_r, count_r;
  logic [CHAR_W-1:0] total_r, code_r;
  logic [ACC_W-1:0]  sum_r, acc_r;
  range_t            cur_r;
  logic              have_cur_r, new_taken_r;
  status_t           status_r;

  range_t ram_q, new_rng, x_rng;
  logic   take, merge_ok, ram_we;
  logic [LEN_W-1:0] first_m1_chk, last_p1;

  assign new_rng.s = first_r;
  assign new_rng.e = last_r;
  assign take      = cmd.take_new | cmd.take_ram;
  assign x_rng     = cmd.take_new ? new_rng : ram_q;
  assign merge_ok  = {1'b0, x_rng.s} <= ({1'b0, cur_r.e} + LEN_W'(1));
  assign ram_we    = (take & have_cur_r & ~merge_ok) | cmd.flush;
  assign first_m1_chk = {1'b0, ram_q.e} + LEN_W'(1);
  assign last_p1      = {1'b0, last_r} + LEN_W'(1);

  arm_ram #(.WIDTH($bits(range_t)), .DEPTH(MAX_RANGES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (w_r[IDX_W-1:0]),
    .wdata (cur_r),
    .re    (cmd.rd),
    .raddr (i_r[IDX_W-1:0]),
    .rdata (ram_q)
  );

  always_comb begin
    sts.is_lookup = op_r;
    sts.ch_zero   = (ch_r == '0);
    sts.empty     = (first_r > last_r);
    sts.full      = (count_r == CNT_W'(MAX_RANGES));
    sts.at_end    = (i_r == count_r);
    sts.lk_hit    = (ram_q.s <= ch_r) && (ch_r <= ram_q.e);
    sts.touch     = (first_m1_chk >= {1'b0, first_r}) && ({1'b0, ram_q.s} <= last_p1);
    sts.new_first = (first_r <= ram_q.s);
    sts.new_taken = new_taken_r;
    sts.rsp_free  = ~rsp_valid | rsp_ready;
  end

  // Item and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r        <= op;
      first_r     <= range_first;
      last_r      <= range_last;
      ch_r        <= character;
      i_r         <= '0;
      w_r         <= '0;
      sum_r       <= '0;
      acc_r       <= ACC_W'(1);
      code_r      <= '0;
      have_cur_r  <= 1'b0;
      new_taken_r <= 1'b0;
    end else begin
      if (cmd.clr_i) begin
        i_r <= '0;
      end else if (cmd.inc_i) begin
        i_r <= i_r + CNT_W'(1);
      end
      if (cmd.acc_add) begin
        acc_r <= acc_r + ACC_W'(range_len(ram_q));
      end
      if (cmd.set_code) begin
        code_r <= sat_char(acc_r + ACC_W'(ch_r) - ACC_W'(ram_q.s));
      end
      if (cmd.take_new) begin
        new_taken_r <= 1'b1;
      end
      if (take) begin
        if (!have_cur_r) begin
          cur_r      <= x_rng;
          have_cur_r <= 1'b1;
        end else if (merge_ok) begin
          if (x_rng.e > cur_r.e) begin
            cur_r.e <= x_rng.e;
          end
        end else begin
          cur_r <= x_rng;
          w_r   <= w_r + CNT_W'(1);
          sum_r <= sum_r + ACC_W'(range_len(cur_r));
        end
      end
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
  end

  // Table state
  always_ff @(posedge clk) begin
    if (rst) begin
      count_r <= '0;
      total_r <= '0;
    end else if (cmd.flush) begin
      count_r <= w_r + CNT_W'(1);
      total_r <= sat_char(sum_r + ACC_W'(range_len(cur_r)));
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_code   <= code_r;
      rsp_status <= status_r;
      rsp_size   <= total_r;
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count_r <= CNT_W'(MAX_RANGES))
    else $error("range count above table depth");

  a_wr_behind_rd: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (w_r <= i_r))
    else $error("range write overtakes the read pointer");

  a_total_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.flush |=> $stable(total_r))
    else $error("alphabet size changed outside a flush");

endmodule
`default_nettype wire

>>> rtl/alphabet_range_map.sv
// Alphabet range map: holds up to MAX_RANGES sorted, disjoint, non-adjacent
// character ranges in a small range memory with separate write and
// registered read ports. An add transaction merges its range with every
// stored range it overlaps or touches (or inserts it in sorted order),
// rewriting the table in one in-place pass; an empty range reports status 1
// and a needed new entry in a full table reports status 2, both leaving the
// table as it was. A lookup transaction returns the dense code of a
// character (0 for character 0, status 3 on a miss). Every response carries
// the current alphabet size, saturated at 2^31-1. One transaction is
// processed at a time, walking the range memory one entry at a time; an add
// into a full table first walks the table to check for a merge. A finished
// response waits in an output register, so the next request is taken while
// the previous response is still pending.
`default_nettype none
module alphabet_range_map (
  input  wire logic clk,
  input  wire logic rst,
  arm_req_if.sink   req,
  arm_rsp_if.source rsp
);
  import arm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer: walks the range memory for each transaction
  arm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Range memory, merge and code arithmetic, response register
  arm_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .op          (req.op),
    .range_first (req.range_first),
    .range_last  (req.range_last),
    .character   (req.character),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_code    (rsp.code),
    .rsp_status  (rsp.status),
    .rsp_size    (rsp.alphabet_size)
  );

endmodule
`default_nettype wire
